### rtl/core/lkvc_pkg.sv
// Shared types and constants of the LRU key-value cache.
// Used by the front, the back end and the top level; depends on nothing.
`default_nettype none

package lkvc_pkg;

  localparam int CAP_W  = 5;
  localparam int KEY_W  = 16;
  localparam int DATA_W = 31;
  localparam int OUT_W  = 32;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } cmd_t;

  // Command after classification by the key lookup.
  typedef struct packed {
    cmd_t cmd;
    logic hit;
  } op_t;

endpackage

`default_nettype wire

### rtl/core/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// A get that hits has out_valid high after lookup, queue, execute, value memory
// read and output register; a miss skips the memory read. A put gives no result.
// A new item is taken only while busy is low: the front holds no command, the
// queue is empty and the back end is idle. The receiver cannot stall.
// Synchronous reset empties the store.
`default_nettype none

module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire                          in_kind,
  input  wire  [lkvc_pkg::KEY_W-1:0]   in_key,
  input  wire  [lkvc_pkg::DATA_W-1:0]  in_data_in,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic signed [lkvc_pkg::OUT_W-1:0] out_data_out,
  input  wire                          cfg_we,
  input  wire  [lkvc_pkg::CAP_W-1:0]   cfg_wdata
);
  import lkvc_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QW = $bits(op_t) + IW;

  cmd_t               cmd;
  logic               accept;
  logic               front_busy, back_busy;
  logic               push, pop, q_nonempty, q_full;
  op_t                push_op, head_op;
  logic [IW-1:0]      push_slot, head_slot;
  logic [ENTRIES-1:0] valid;
  logic               key_we;
  logic [IW-1:0]      key_wslot;
  logic [KEY_W-1:0]   key_wdata;
  logic [OUT_W-1:0]   data_out;

  assign cmd.kind = in_kind;
  assign cmd.key  = in_key;
  assign cmd.data = in_data_in;

  assign busy   = front_busy | q_nonempty | back_busy;
  assign accept = start && !busy;
  assign out_data_out = $signed(data_out);

  lkvc_front #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (accept),
    .cmd_i       (cmd),
    .valid_i     (valid),
    .key_we_i    (key_we),
    .key_wslot_i (key_wslot),
    .key_wdata_i (key_wdata),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_op_o   (push_op),
    .push_slot_o (push_slot),
    .busy_o      (front_busy)
  );

  lkvc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i ({push_op, push_slot}),
    .pop_i       (pop),
    .head_o      ({head_op, head_slot}),
    .nonempty_o  (q_nonempty),
    .full_o      (q_full)
  );

  lkvc_back #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .q_nonempty_i (q_nonempty),
    .q_op_i       (head_op),
    .q_slot_i     (head_slot),
    .q_pop_o      (pop),
    .valid_o      (valid),
    .key_we_o     (key_we),
    .key_wslot_o  (key_wslot),
    .key_wdata_o  (key_wdata),
    .busy_o       (back_busy),
    .out_valid_o  (out_valid),
    .out_hit_o    (out_hit),
    .out_data_o   (data_out)
  );

endmodule

`default_nettype wire

### rtl/core/lkvc_front.sv
// Front part: takes commands, holds the key store and classifies each
// command as hit or miss. Depends on lkvc_pkg.
`default_nettype none

module lkvc_front #(
  parameter int ENTRIES = 16,
  parameter int IW      = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  accept_i,
  input  lkvc_pkg::cmd_t       cmd_i,
  input  wire  [ENTRIES-1:0]   valid_i,
  input  wire                  key_we_i,
  input  wire  [IW-1:0]        key_wslot_i,
  input  wire  [lkvc_pkg::KEY_W-1:0] key_wdata_i,
  input  wire                  q_full_i,
  output logic                 push_o,
  output lkvc_pkg::op_t        push_op_o,
  output logic [IW-1:0]        push_slot_o,
  output logic                 busy_o
);
  import lkvc_pkg::*;

  logic             cmd_valid_r, cmd_valid_nxt;
  cmd_t             cmd_r;
  logic [KEY_W-1:0] key_r [ENTRIES];
  logic             hit;
  logic [IW-1:0]    slot;

  // Keys are unique among valid entries, so the match index is an OR of
  // at most one term.
  always_comb begin
    hit  = 1'b0;
    slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_i[i] && key_r[i] == cmd_r.key) begin
        hit  = 1'b1;
        slot = slot | IW'(i);
      end
    end
  end

  assign push_o          = cmd_valid_r && !q_full_i;
  assign push_op_o.cmd   = cmd_r;
  assign push_op_o.hit   = hit;
  assign push_slot_o     = slot;
  assign busy_o          = cmd_valid_r;

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    if (push_o) begin
      cmd_valid_nxt = 1'b0;
    end
    if (accept_i) begin
      cmd_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_i) begin
      cmd_r <= cmd_i;
    end
    if (key_we_i) begin
      key_r[key_wslot_i] <= key_wdata_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lkvc_queue.sv
// Two-entry queue between the front and the back end.
// Generic over its payload width; no package use.
`default_nettype none

module lkvc_queue #(
  parameter int WIDTH = 8
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_i,
  input  wire  [WIDTH-1:0] push_data_i,
  input  wire              pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             nonempty_o,
  output logic             full_o
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign head_o     = slot_r[rd_ptr_r];
  assign nonempty_o = (cnt_r != 2'd0);
  assign full_o     = (cnt_r == 2'd2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop_i) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      slot_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lkvc_back.sv
// Back end: recency ages, valid bits, occupancy, capacity register and
// the value memory; carries out classified commands. Depends on lkvc_pkg.
`default_nettype none

module lkvc_back #(
  parameter int ENTRIES = 16,
  parameter int IW      = 4
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we_i,
  input  wire  [lkvc_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  wire                          q_nonempty_i,
  input  lkvc_pkg::op_t                q_op_i,
  input  wire  [IW-1:0]                q_slot_i,
  output logic                         q_pop_o,
  output logic [ENTRIES-1:0]           valid_o,
  output logic                         key_we_o,
  output logic [IW-1:0]                key_wslot_o,
  output logic [lkvc_pkg::KEY_W-1:0]   key_wdata_o,
  output logic                         busy_o,
  output logic                         out_valid_o,
  output logic                         out_hit_o,
  output logic [lkvc_pkg::OUT_W-1:0]   out_data_o
);
  import lkvc_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  op_t                 op_r;
  logic [IW-1:0]       slot_r;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [IW-1:0]       age_r [ENTRIES];
  logic [IW-1:0]       age_nxt [ENTRIES];
  logic [CW-1:0]       used_r, used_nxt;
  logic [CAP_W-1:0]    cap_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  logic [DATA_W-1:0]   mem [ENTRIES];
  logic [DATA_W-1:0]   rd_q;
  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr;

  logic [EW-1:0]       ecap;
  logic                full;
  logic [IW-1:0]       oldest_age;
  logic [IW-1:0]       touch_age;
  logic [ENTRIES-1:0]  evict_oh;
  logic [ENTRIES-1:0]  free_vec;
  logic [IW-1:0]       free_slot;
  logic                free_found;

  // A capacity of zero acts as one, anything above ENTRIES as ENTRIES.
  always_comb begin
    if (cap_r == '0) begin
      ecap = EW'(1);
    end else if (EW'(cap_r) > EW'(ENTRIES)) begin
      ecap = EW'(ENTRIES);
    end else begin
      ecap = EW'(cap_r);
    end
  end

  assign full = (EW'(used_r) >= ecap);

  // Valid ages always form 0 .. used-1, so the oldest entry is the one
  // whose age equals used-1.
  assign oldest_age = IW'(used_r - CW'(1));

  always_comb begin
    touch_age  = '0;
    evict_oh   = '0;
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_r == IW'(i)) begin
        touch_age = age_r[i];
      end
      evict_oh[i] = full && valid_r[i] && (age_r[i] == oldest_age);
    end
    free_vec = ~valid_r | evict_oh;
    for (int i = 0; i < ENTRIES; i++) begin
      if (free_vec[i] && !free_found) begin
        free_slot  = IW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign q_pop_o     = (state_r == S_IDLE) && q_nonempty_i;
  assign busy_o      = (state_r != S_IDLE);
  assign valid_o     = valid_r;
  assign out_valid_o = out_valid_r;
  assign out_hit_o   = out_hit_r;
  assign out_data_o  = out_data_r;
  assign key_wslot_o = free_slot;
  assign key_wdata_o = op_r.cmd.key;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    used_nxt      = used_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = out_hit_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = slot_r;
    key_we_o      = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      age_nxt[i] = age_r[i];
    end

    case (state_r)
      S_IDLE: begin
        if (q_nonempty_i) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (op_r.hit) begin
          // Refresh: entries younger than the touched one age by one.
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_r == IW'(i)) begin
              age_nxt[i] = '0;
            end else if (valid_r[i] && age_r[i] < touch_age) begin
              age_nxt[i] = age_r[i] + IW'(1);
            end
          end
          if (op_r.cmd.kind == KIND_GET) begin
            mem_re    = 1'b1;
            state_nxt = S_RESP;
          end else begin
            mem_we = 1'b1;
          end
        end else if (op_r.cmd.kind == KIND_GET) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b0;
          out_data_nxt  = '1;
        end else begin
          // Insert, evicting the oldest entry first when full.
          for (int i = 0; i < ENTRIES; i++) begin
            if (free_slot == IW'(i)) begin
              age_nxt[i]   = '0;
              valid_nxt[i] = 1'b1;
            end else if (valid_r[i] && !evict_oh[i]) begin
              age_nxt[i] = age_r[i] + IW'(1);
            end else begin
              valid_nxt[i] = 1'b0;
            end
          end
          if (!full) begin
            used_nxt = used_r + CW'(1);
          end
          mem_we    = 1'b1;
          mem_waddr = free_slot;
          key_we_o  = 1'b1;
        end
      end
      S_RESP: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_hit_nxt   = 1'b1;
        out_data_nxt  = {1'b0, rd_q};
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      used_r      <= '0;
      cap_r       <= CAP_W'(16);
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= age_nxt[i];
      end
      if (cfg_we_i) begin
        cap_r <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r  <= out_hit_nxt;
    out_data_r <= out_data_nxt;
    if (q_pop_o) begin
      op_r   <= q_op_i;
      slot_r <= q_slot_i;
    end
  end

  // Value memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= op_r.cmd.data;
    end
    if (mem_re) begin
      rd_q <= mem[slot_r];
    end
  end

endmodule

`default_nettype wire

### verif/cache_mirror_pkg.sv
// Scoreboard for the LRU key-value cache testbench: a mirror of the store that
// predicts every lookup and checks the results. Depends on lkvc_pkg.
package cache_mirror_pkg;
  import lkvc_pkg::*;

  localparam int SLOTS = 16;

  typedef struct packed {
    logic             hit;
    logic [OUT_W-1:0] data;
  } lookup_t;

  class cache_mirror;
    bit                slot_valid[SLOTS];
    logic [KEY_W-1:0]  slot_key[SLOTS];
    logic [DATA_W-1:0] slot_data[SLOTS];
    int unsigned       slot_age[SLOTS];
    int unsigned       occupancy;
    logic [CAP_W-1:0]  capacity;
    lookup_t           pending_lookups[$];
    int unsigned       mismatches;

    function new();
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_age[i] = 0;
      end
      occupancy = 0;
      capacity = 5'd16;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    // Zero behaves as one and anything above the slot count as the slot count.
    function int unsigned active_capacity();
      int unsigned c;
      c = capacity;
      if (c < 1) c = 1;
      if (c > SLOTS) c = SLOTS;
      return c;
    endfunction

    function int find_slot(logic [KEY_W-1:0] k);
      for (int i = 0; i < SLOTS; i++)
        if (slot_valid[i] && slot_key[i] == k) return i;
      return -1;
    endfunction

    // Only slots younger than the touched one grow older.
    function void refresh(int s);
      int unsigned a;
      a = slot_age[s];
      for (int i = 0; i < SLOTS; i++)
        if (slot_valid[i] && i != s && slot_age[i] < a) slot_age[i]++;
      slot_age[s] = 0;
    endfunction

    function void evict_lru();
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++)
        if (slot_valid[i] && (best < 0 || slot_age[i] > slot_age[best])) best = i;
      if (best >= 0) begin
        slot_valid[best] = 1'b0;
        if (occupancy > 0) occupancy--;
      end
    endfunction

    function void insert_entry(logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
      int free_slot;
      free_slot = -1;
      if (occupancy >= active_capacity()) evict_lru();
      for (int i = SLOTS - 1; i >= 0; i--)
        if (!slot_valid[i]) free_slot = i;
      if (free_slot < 0) return;
      for (int i = 0; i < SLOTS; i++)
        if (slot_valid[i] && slot_age[i] < 255) slot_age[i]++;
      slot_valid[free_slot] = 1'b1;
      slot_key[free_slot] = k;
      slot_data[free_slot] = v;
      slot_age[free_slot] = 0;
      occupancy++;
    endfunction

    // Applies one accepted item to the mirror; a get queues its expected result.
    function void note_command(logic kind, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
      int s;
      lookup_t r;
      s = find_slot(k);
      if (kind == KIND_GET) begin
        if (s >= 0) begin
          refresh(s);
          r.hit = 1'b1;
          r.data = {1'b0, slot_data[s]};
        end else begin
          r.hit = 1'b0;
          r.data = '1;
        end
        pending_lookups.push_back(r);
      end else if (s >= 0) begin
        slot_data[s] = v;
        refresh(s);
      end else begin
        insert_entry(k, v);
      end
    endfunction

    function void flag(string what, lookup_t want, logic hit, logic [OUT_W-1:0] d);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch (%s): expected hit=%0b data=%h, got hit=%0b data=%h",
                 what, want.hit, want.data, hit, d);
    endfunction

    function void check_result(logic hit, logic [OUT_W-1:0] d);
      lookup_t want;
      if (pending_lookups.size() == 0) begin
        want = '0;
        flag("no lookup outstanding", want, hit, d);
      end else begin
        want = pending_lookups.pop_front();
        if (hit !== want.hit || d !== want.data) flag("lookup", want, hit, d);
      end
    endfunction
  endclass

endpackage

### verif/tb_top.sv
// Top of the LRU key-value cache testbench: clock, reset, item driver and monitor.
// Depends on lkvc_pkg, cache_mirror_pkg and the lru_key_value_cache RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;
  import cache_mirror_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int POOL_SIZE     = 24;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    in_kind;
  logic [KEY_W-1:0]        in_key;
  logic [DATA_W-1:0]       in_data_in;
  logic                    out_valid;
  logic                    out_hit;
  logic signed [OUT_W-1:0] out_data_out;
  logic                    cfg_we;
  logic [CAP_W-1:0]        cfg_wdata;

  cache_mirror      tracker;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int unsigned      burst_left;
  int unsigned      quiet_cycles = 0;

  lru_key_value_cache #(.ENTRIES(SLOTS)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_key       (in_key),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_hit      (out_hit),
    .out_data_out (out_data_out),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Results are checked before the item accepted on the same edge is applied.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_result(out_hit, out_data_out);
      if (start && !busy) tracker.note_command(in_kind, in_key, in_data_in);
      if (cfg_we) tracker.set_capacity(cfg_wdata);
      if (out_valid || (start && !busy) || cfg_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(logic kind, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
    @(negedge clk);
    start <= 1'b1;
    in_kind <= kind;
    in_key <= k;
    in_data_in <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(int unsigned n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Waits until every lookup has returned and the last put has been applied.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending_lookups.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Keys come mostly from a small pool so that hits, updates and evictions are common.
  task automatic random_phase(logic [CAP_W-1:0] cap, int unsigned span, int unsigned count);
    logic             kind;
    logic [KEY_W-1:0] k;
    write_capacity(cap);
    repeat (count) begin
      kind = ($urandom_range(0, 1) == 0) ? KIND_GET : KIND_PUT;
      k = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, span - 1)]
                                      : KEY_W'($urandom);
      if (burst_left == 0) begin
        pause_sender($urandom_range(1, 12));
        burst_left = $urandom_range(1, 16);
      end
      send_item(kind, k, DATA_W'($urandom));
      burst_left--;
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_GET;
    in_key = '0;
    in_data_in = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    burst_left = 0;
    tracker = new();
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // A lookup in the empty store misses whatever its data field holds.
    send_item(KIND_GET, 16'h0000, 31'h7FFFFFFF);
    send_item(KIND_PUT, 16'h0000, 31'h00000000);
    send_item(KIND_PUT, 16'hFFFF, 31'h7FFFFFFF);
    send_item(KIND_GET, 16'h0000, 31'h7FFFFFFF);
    send_item(KIND_GET, 16'hFFFF, 31'h00000000);
    send_item(KIND_GET, 16'h1234, 31'h00000000);
    send_item(KIND_PUT, 16'hFFFF, 31'h2AAAAAAA);
    send_item(KIND_GET, 16'hFFFF, 31'h00000000);
    send_item(KIND_PUT, 16'h5555, 31'h55555555);
    // Capacity drops below the three entries held; each insert now evicts one.
    write_capacity(5'd1);
    send_item(KIND_PUT, 16'hAAAA, 31'h00000001);
    send_item(KIND_GET, 16'h0000, 31'h00000000);
    send_item(KIND_GET, 16'hFFFF, 31'h00000000);
    send_item(KIND_GET, 16'h5555, 31'h00000000);
    send_item(KIND_GET, 16'hAAAA, 31'h00000000);
    send_item(KIND_PUT, 16'h0F0F, 31'h0F0F0F0F);
    send_item(KIND_GET, 16'hAAAA, 31'h00000000);
    send_item(KIND_GET, 16'h0F0F, 31'h00000000);

    // A capacity above the slot count acts as the slot count, zero acts as one.
    random_phase(5'd31, 24, 80);
    random_phase(5'd3, 6, 60);
    random_phase(5'd0, 3, 40);
    random_phase(5'd16, 20, 80);
    random_phase(5'd8, 12, 60);
    random_phase(5'd1, 3, 40);

    drain();
    if (tracker.mismatches == 0 && tracker.pending_lookups.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
